/* hdl/bcs_pkg.sv */
// shared types and constants for the bad-character string search block
`timescale 1ns / 1ps

package bcs_pkg;

  localparam int CHAR_W    = 8;
  localparam int POS_W     = 10;
  localparam int PAT_W     = 64;
  localparam int PLEN_W    = 4;
  localparam int JIDX_W    = 3;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

  typedef struct packed {
    logic              command;
    logic [CHAR_W-1:0] text_char;
    logic              new_text;
  } in_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } out_rsp_t;

  typedef struct packed {
    logic [PAT_W-1:0]  pattern_bytes;
    logic [PLEN_W-1:0] pattern_length;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic res_valid;
  } bcs_status_t;

endpackage

/* hdl/bcs_shift_unit.sv */
// bad-character shift unit: last position lookup and step computation
`timescale 1ns / 1ps

module bcs_shift_unit #(
  parameter int PATTERN_MAX = 8
) (
  input  logic [PATTERN_MAX-1:0][bcs_pkg::CHAR_W-1:0] snap,
  input  logic [bcs_pkg::PLEN_W-1:0]                  snap_len,
  input  logic [bcs_pkg::PLEN_W-1:0]                  gap,
  input  logic [bcs_pkg::CHAR_W-1:0]                  chr,
  output logic [bcs_pkg::STEP_W-1:0]                  step
);

  logic signed [4:0] last;
  logic signed [5:0] diff;

  // last pattern position holding this character, -1 when absent
  always_comb begin
    last = -5'sd1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (bcs_pkg::PLEN_W'(i) < snap_len && snap[i] == chr) begin
        last = 5'(i);
      end
    end
  end

  assign diff = $signed({2'b00, gap}) - $signed({last[4], last});
  assign step = (diff < 6'sd1) ? bcs_pkg::STEP_W'(1) : diff[bcs_pkg::STEP_W-1:0];

endmodule

/* hdl/bcs_engine.sv */
// text store, search sequencer and shift register of the string search
`timescale 1ns / 1ps

module bcs_engine #(
  parameter int TEXT_DEPTH    = 1024,
  parameter int PATTERN_MAX   = 8,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bcs_pkg::in_req_t     req,
  input  bcs_pkg::cfg_t        cfg,
  input  logic                 res_take,
  output bcs_pkg::bcs_status_t status,
  output bcs_pkg::out_rsp_t    res
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int CW = $clog2(TEXT_DEPTH + 1);
  localparam int SW = $clog2(TEXT_DEPTH + PATTERN_MAX + 2);
  localparam logic [CW-1:0] DEPTH_C = CW'(TEXT_DEPTH);
  localparam logic [bcs_pkg::PLEN_W-1:0] MAX_LEN = bcs_pkg::PLEN_W'(PATTERN_MAX);

  typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_CMP, ST_NEXT, ST_DONE} state_t;

  function automatic logic [bcs_pkg::PLEN_W-1:0] eff_len(
    input logic [bcs_pkg::PLEN_W-1:0] l
  );
    logic [bcs_pkg::PLEN_W-1:0] r;
    r = l;
    if (l == '0) r = bcs_pkg::PLEN_W'(1);
    else if (l > MAX_LEN) r = MAX_LEN;
    return r;
  endfunction

  function automatic logic [bcs_pkg::CHAR_W-1:0] alpha_mod(
    input logic [bcs_pkg::CHAR_W-1:0] b
  );
    return bcs_pkg::CHAR_W'(b % ALPHABET_SIZE);
  endfunction

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, count_base;
  logic [SW-1:0] shift_r, shift_nxt;
  logic [bcs_pkg::JIDX_W-1:0] j_r, j_nxt;
  logic [bcs_pkg::PLEN_W-1:0] m_r, m_nxt;
  logic res_found_r, res_found_nxt;
  logic [bcs_pkg::POS_W-1:0] res_pos_r, res_pos_nxt;
  logic [PATTERN_MAX-1:0][bcs_pkg::CHAR_W-1:0] snap_r, snap_nxt;
  logic [bcs_pkg::PLEN_W-1:0] snap_len_r, snap_len_nxt;

  logic [bcs_pkg::CHAR_W-1:0] mem [TEXT_DEPTH];
  logic [bcs_pkg::CHAR_W-1:0] rdata_r;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [bcs_pkg::PLEN_W-1:0] addr_off;

  logic [SW:0]                sum_m;
  logic [SW:0]                cnt_ext;
  logic [bcs_pkg::CHAR_W-1:0] pat_chr;
  logic [bcs_pkg::PLEN_W-1:0] gap;
  logic [bcs_pkg::STEP_W-1:0] step;

  assign sum_m   = {1'b0, shift_r} + (SW + 1)'(m_r);
  assign cnt_ext = (SW + 1)'(count_r);
  assign pat_chr = cfg.pattern_bytes[8 * j_r +: 8];
  assign rd_addr = AW'(shift_r + SW'(addr_off));
  assign gap     = (state_r == ST_NEXT) ? m_r : {1'b0, j_r};

  bcs_shift_unit #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_shift (
    .snap    (snap_r),
    .snap_len(snap_len_r),
    .gap     (gap),
    .chr     (alpha_mod(rdata_r)),
    .step    (step)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    shift_nxt     = shift_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    snap_nxt      = snap_r;
    snap_len_nxt  = snap_len_r;
    wr_en         = 1'b0;
    addr_off      = '0;
    count_base    = req.new_text ? '0 : count_r;
    wr_addr       = count_base[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (req.command == bcs_pkg::CMD_FIND) begin
            m_nxt     = eff_len(cfg.pattern_length);
            state_nxt = ST_CHECK;
          end else begin
            if (req.new_text) begin
              shift_nxt    = '0;
              snap_len_nxt = eff_len(cfg.pattern_length);
              for (int i = 0; i < PATTERN_MAX; i++) begin
                snap_nxt[i] = alpha_mod(cfg.pattern_bytes[8 * i +: 8]);
              end
            end
            count_nxt = count_base;
            if (count_base < DEPTH_C) begin
              wr_en     = 1'b1;
              count_nxt = count_base + CW'(1);
            end
          end
        end
      end
      ST_CHECK: begin
        if (sum_m <= cnt_ext) begin
          j_nxt     = bcs_pkg::JIDX_W'(m_r - bcs_pkg::PLEN_W'(1));
          addr_off  = m_r - bcs_pkg::PLEN_W'(1);
          state_nxt = ST_CMP;
        end else begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = ST_DONE;
        end
      end
      ST_CMP: begin
        if (pat_chr == rdata_r) begin
          if (j_r == '0) begin
            res_found_nxt = 1'b1;
            res_pos_nxt   = bcs_pkg::POS_W'(shift_r);
            if (sum_m < cnt_ext) begin
              addr_off  = m_r;
              state_nxt = ST_NEXT;
            end else begin
              shift_nxt = shift_r + SW'(1);
              state_nxt = ST_DONE;
            end
          end else begin
            j_nxt    = j_r - bcs_pkg::JIDX_W'(1);
            addr_off = {1'b0, j_r} - bcs_pkg::PLEN_W'(1);
          end
        end else begin
          shift_nxt = shift_r + SW'(step);
          state_nxt = ST_CHECK;
        end
      end
      ST_NEXT: begin
        shift_nxt = shift_r + SW'(step);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      shift_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      shift_r <= shift_nxt;
    end
    j_r         <= j_nxt;
    m_r         <= m_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    snap_r      <= snap_nxt;
    snap_len_r  <= snap_len_nxt;
  end

  // text store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= req.text_char;
    rdata_r <= mem[rd_addr];
  end

  assign status.ready      = (state_r == ST_IDLE);
  assign status.res_valid  = (state_r == ST_DONE);
  assign res.found          = res_found_r;
  assign res.match_position = res_pos_r;

endmodule

/* hdl/bad_character_string_search.sv */
// top level of the bad-character string search block
`timescale 1ns / 1ps

// Holds a text and searches it for a short pattern with the bad-character rule.
// Input requests: command 0 appends text_char to the text (new_text first clears
// the text and the search position and captures the pattern for the shift
// lookup); command 1 looks for the next match from the current position.
// An append gives no result and leaves the block ready for the next request. A find gives one result:
// found with the start offset, or not found with offset 0.
// A find's result reaches out_data after a bound check for every alignment
// tried (the one that runs off the end of the text included), a compare for
// every pattern byte compared and a read of the next text byte when a match
// is followed by another text byte. All compares go one byte a cycle through
// the single read port of the text memory and one shared shift unit; the next
// request is taken in the cycle the result appears.
// in_stall is high while a find is in progress and while its result waits for
// the output register; appends are still taken while a result sits there.
// The result stays on out_data while out_stall is high.
// Reset (synchronous, rst_n low) empties the text, zeroes the search position
// and loads the register defaults; a new_text append must precede any find.
// cfg writes are to be taken only while no request is in flight; the block does not enforce this.
module bad_character_string_search #(
  parameter int TEXT_DEPTH    = 1024,
  parameter int PATTERN_MAX   = 8,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bcs_pkg::in_req_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bcs_pkg::out_rsp_t                 out_data,
  input  logic                              cfg_wr_en,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcs_pkg::PAT_W-1:0]         cfg_wdata
);

  bcs_pkg::cfg_t       cfg_r;
  bcs_pkg::bcs_status_t eng_status;
  bcs_pkg::out_rsp_t   eng_res;
  bcs_pkg::out_rsp_t   out_data_r;
  logic                out_valid_r;
  logic                in_accept;
  logic                res_take;

  assign in_stall  = !eng_status.ready;
  assign in_accept = in_valid && !in_stall;
  assign res_take  = eng_status.res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes  <= bcs_pkg::PAT_W'(64'd6780001);
      cfg_r.pattern_length <= bcs_pkg::PLEN_W'(3);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bcs_pkg::REG_PATTERN_BYTES:  cfg_r.pattern_bytes  <= cfg_wdata;
        bcs_pkg::REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_wdata[bcs_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  bcs_engine #(
    .TEXT_DEPTH   (TEXT_DEPTH),
    .PATTERN_MAX  (PATTERN_MAX),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_accept),
    .req     (in_data),
    .cfg     (cfg_r),
    .res_take(res_take),
    .status  (eng_status),
    .res     (eng_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) out_data_r <= eng_res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_find_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.command == bcs_pkg::CMD_FIND |=> in_stall)
    else $error("find request did not hold off the input");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_position == '0)
    else $error("not-found result carries a position");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid && !eng_status.res_valid)
    else $error("result handover lost");

endmodule

/* tb/bcs_search_checker.sv */
// scoreboard for the bad-character string search: predicts every find and checks each result
`timescale 1ns / 1ps

module bcs_search_checker #(
  parameter int TEXT_DEPTH    = 1024,
  parameter int PATTERN_MAX   = 8,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  bcs_pkg::in_req_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  bcs_pkg::out_rsp_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [bcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcs_pkg::PAT_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            results_checked,
  output int                            matches_seen
);

  localparam logic [bcs_pkg::PAT_W-1:0]  PAT_RESET  = 64'd6780001;
  localparam logic [bcs_pkg::PLEN_W-1:0] PLEN_RESET = 4'd3;

  logic [bcs_pkg::PAT_W-1:0]  pat_reg;
  logic [bcs_pkg::PLEN_W-1:0] plen_reg;
  logic [bcs_pkg::CHAR_W-1:0] text_mem [TEXT_DEPTH];
  int                         text_len;
  int                         shift_pos;
  int                         last_pos [ALPHABET_SIZE];
  bcs_pkg::out_rsp_t          expected_matches [$];
  bcs_pkg::out_rsp_t          want;
  bcs_pkg::out_rsp_t          predicted;
  int                         mismatches;
  int                         checked;
  int                         hits;

  // length in use, clamped into 1..PATTERN_MAX
  function automatic int search_len();
    if (plen_reg == 0) return 1;
    if (plen_reg > PATTERN_MAX) return PATTERN_MAX;
    return int'(plen_reg);
  endfunction

  function automatic logic [bcs_pkg::CHAR_W-1:0] pat_char(input int idx);
    return pat_reg[bcs_pkg::CHAR_W*idx +: bcs_pkg::CHAR_W];
  endfunction

  function automatic int skip_by(input int d);
    return (d < 1) ? 1 : d;
  endfunction

  function automatic int last_of(input logic [bcs_pkg::CHAR_W-1:0] c);
    return last_pos[int'(c) % ALPHABET_SIZE];
  endfunction

  task automatic rebuild_table();
    int m;
    m = search_len();
    for (int i = 0; i < ALPHABET_SIZE; i++) last_pos[i] = -1;
    for (int i = 0; i < m; i++) last_pos[int'(pat_char(i)) % ALPHABET_SIZE] = i;
  endtask

  task automatic take_append(input logic [bcs_pkg::CHAR_W-1:0] c, input logic restart);
    if (restart) begin
      text_len  = 0;
      shift_pos = 0;
      rebuild_table();
    end
    if (text_len < TEXT_DEPTH) begin
      text_mem[text_len] = c;
      text_len++;
    end
  endtask

  // scans right to left from the current shift, moves the shift on
  function automatic bcs_pkg::out_rsp_t predict_find();
    bcs_pkg::out_rsp_t r;
    int m, s, j;
    bit hit;
    m   = search_len();
    s   = shift_pos;
    hit = 1'b0;
    r   = '0;
    while (!hit && s + m <= text_len) begin
      j = m - 1;
      while (j >= 0 && pat_char(j) == text_mem[s + j]) j--;
      if (j < 0) begin
        hit              = 1'b1;
        r.found          = 1'b1;
        r.match_position = s[bcs_pkg::POS_W-1:0];
        if (s + m < text_len) s += skip_by(m - last_of(text_mem[s + m]));
        else s += 1;
      end else begin
        s += skip_by(j - last_of(text_mem[s + j]));
      end
    end
    shift_pos = s;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_reg   = PAT_RESET;
      plen_reg  = PLEN_RESET;
      text_len  = 0;
      shift_pos = 0;
      for (int i = 0; i < ALPHABET_SIZE; i++) last_pos[i] = 0;
      expected_matches.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          bcs_pkg::REG_PATTERN_BYTES:  pat_reg = cfg_wdata;
          bcs_pkg::REG_PATTERN_LENGTH: plen_reg = cfg_wdata[bcs_pkg::PLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.command == bcs_pkg::CMD_APPEND) begin
          take_append(in_data.text_char, in_data.new_text);
        end else begin
          predicted        = predict_find();
          expected_matches = {expected_matches, predicted};
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          $error("unexpected result: found %0b match_position %0d",
                 out_data.found, out_data.match_position);
          mismatches++;
        end else begin
          want = expected_matches.pop_front();
          checked++;
          if (want.found) hits++;
          if (out_data.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_data.found);
            mismatches++;
          end
          if (out_data.match_position !== want.match_position) begin
            $error("match_position: expected %0d, got %0d",
                   want.match_position, out_data.match_position);
            mismatches++;
          end
        end
      end
    end
    fail_count      <= mismatches;
    pending         <= expected_matches.size();
    results_checked <= checked;
    matches_seen    <= hits;
  end

endmodule

/* tb/bad_character_string_search_tb.sv */
// top of the testbench: clock, reset, request stimulus, output back-pressure and the verdict
`timescale 1ns / 1ps

module bad_character_string_search_tb;

  localparam int TEXT_DEPTH  = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 400;
  localparam int PER_SETTING = 10;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  bcs_pkg::in_req_t              in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  bcs_pkg::out_rsp_t             out_data;
  logic                          cfg_wr_en = 1'b0;
  logic [bcs_pkg::CFG_IDX_W-1:0] cfg_index = bcs_pkg::REG_PATTERN_BYTES;
  logic [bcs_pkg::PAT_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int pending;
  int results_checked;
  int matches_seen;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int sent_total     = 0;
  int sent_finds     = 0;

  logic [bcs_pkg::PAT_W-1:0] cur_pattern = 64'd6780001;
  int                        plant_len   = 3;

  bad_character_string_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bcs_search_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .matches_seen    (matches_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side back-pressure, with an occasional long hold
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic offer_request(input logic cmd, input logic [bcs_pkg::CHAR_W-1:0] ch,
                               input logic nt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, text_char: ch, new_text: nt};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
    if (cmd == bcs_pkg::CMD_FIND) sent_finds++;
  endtask

  task automatic settle(input int drain);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (drain) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [bcs_pkg::PAT_W-1:0] pat,
                           input logic [bcs_pkg::PLEN_W-1:0] len);
    settle(4);
    cfg_wr_en <= 1'b1;
    cfg_index <= bcs_pkg::REG_PATTERN_BYTES;
    cfg_wdata <= pat;
    @(posedge clk);
    cfg_index <= bcs_pkg::REG_PATTERN_LENGTH;
    cfg_wdata <= {{(bcs_pkg::PAT_W-bcs_pkg::PLEN_W){1'b0}}, len};
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_pattern = pat;
    plant_len   = (len == 0) ? 1 : (len > 8) ? 8 : int'(len);
  endtask

  task automatic apply_setting(input int k);
    logic [bcs_pkg::CHAR_W-1:0] b0, b1, b2;
    logic [bcs_pkg::PAT_W-1:0]  pat;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    case (k % 6)
      0: write_cfg('0, 4'd1);
      1: write_cfg('1, 4'd8);
      2: write_cfg({$urandom, $urandom}, 4'd0);
      3: write_cfg({$urandom, $urandom}, 4'd15);
      4: write_cfg({8{b0}}, 4'($urandom_range(1, 8)));
      default: begin
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(2))
            0: pat[8*i +: 8] = b0;
            1: pat[8*i +: 8] = b1;
            default: pat[8*i +: 8] = b2;
          endcase
        end
        write_cfg(pat, 4'($urandom_range(1, 8)));
      end
    endcase
  endtask

  // text bytes: half of them pattern bytes, the rest two others, sometimes anything
  function automatic logic [bcs_pkg::CHAR_W-1:0] pick_char(
    input logic [bcs_pkg::CHAR_W-1:0] spare_a,
    input logic [bcs_pkg::CHAR_W-1:0] spare_b,
    input bit wide);
    int idx;
    idx = $urandom_range(plant_len - 1);
    if (wide) return 8'($urandom);
    case ($urandom_range(3))
      0: return spare_a;
      1: return spare_b;
      default: return cur_pattern[8*idx +: 8];
    endcase
  endfunction

  // new text, a few planted copies of the pattern, a run of finds, sometimes more appends and finds
  task automatic run_sequence(input int n, input int finds);
    logic [bcs_pkg::CHAR_W-1:0] spare_a, spare_b;
    logic [bcs_pkg::CHAR_W-1:0] text_buf [TEXT_DEPTH + 8];
    bit                         wide;
    int                         p, k;
    spare_a = 8'($urandom);
    spare_b = 8'($urandom);
    wide    = ($urandom_range(4) == 0);
    for (k = 0; k < n; k++) text_buf[k] = pick_char(spare_a, spare_b, wide);
    if (n >= plant_len) begin
      repeat ($urandom_range(3)) begin
        p = $urandom_range(n - plant_len);
        for (k = 0; k < plant_len; k++) text_buf[p + k] = cur_pattern[8*k +: 8];
      end
      if (n >= TEXT_DEPTH) begin
        for (k = 0; k < plant_len; k++) begin
          text_buf[TEXT_DEPTH - plant_len + k] = cur_pattern[8*k +: 8];
        end
      end
    end
    for (k = 0; k < n; k++) offer_request(bcs_pkg::CMD_APPEND, text_buf[k], k == 0);
    repeat (finds) offer_request(bcs_pkg::CMD_FIND, 8'($urandom), $urandom_range(4) == 0);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        offer_request(bcs_pkg::CMD_APPEND, pick_char(spare_a, spare_b, wide), 1'b0);
      end
      repeat ($urandom_range(1, 3)) offer_request(bcs_pkg::CMD_FIND, 8'($urandom), 1'b0);
    end
  endtask

  initial begin
    logic [bcs_pkg::CHAR_W-1:0] seed_text [7];
    int                         stop_at;
    seed_text = '{8'h78, 8'h61, 8'h74, 8'h67, 8'h61, 8'h74, 8'h67};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset pattern "atg" over "xatgatg": two hits, then exhausted twice
    for (int k = 0; k < 7; k++) offer_request(bcs_pkg::CMD_APPEND, seed_text[k], k == 0);
    repeat (3) offer_request(bcs_pkg::CMD_FIND, 8'h00, 1'b0);
    offer_request(bcs_pkg::CMD_FIND, 8'hFF, 1'b1);
    // growing the text revives the search
    offer_request(bcs_pkg::CMD_APPEND, 8'h61, 1'b0);
    offer_request(bcs_pkg::CMD_APPEND, 8'h74, 1'b0);
    offer_request(bcs_pkg::CMD_APPEND, 8'h67, 1'b0);
    offer_request(bcs_pkg::CMD_FIND, 8'h00, 1'b0);
    // text shorter than the pattern
    offer_request(bcs_pkg::CMD_APPEND, 8'hFF, 1'b1);
    offer_request(bcs_pkg::CMD_APPEND, 8'h00, 1'b0);
    offer_request(bcs_pkg::CMD_FIND, 8'h00, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  <= 25;
          recv_stall_pct <= 77;
        end
        1: begin
          send_idle_pct  <= 77;
          recv_stall_pct <= 25;
        end
        default: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
          // overfilled text, pattern planted at the very end
          write_cfg({$urandom, $urandom}, 4'd8);
          run_sequence(TEXT_DEPTH + 6, 8);
        end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        apply_setting(3 * phase + sub);
        if (phase == 0 && sub == 1) hold_asks <= hold_asks + 1;
        // new registers against the table built earlier
        if ($urandom_range(1)) begin
          repeat ($urandom_range(1, 3)) offer_request(bcs_pkg::CMD_FIND, 8'($urandom), 1'b0);
        end
        stop_at = sent_total + PER_SETTING;
        while (sent_total < stop_at) begin
          if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 10)) offer_request(1'($urandom), 8'($urandom), 1'($urandom));
          end else begin
            run_sequence(($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40),
                         $urandom_range(1, 8));
          end
        end
      end
    end

    settle(20);
    $display("run: %0d requests, %0d of them finds; %0d results checked, %0d matches",
             sent_total, sent_finds, results_checked, matches_seen);
    $display("run: pattern lengths 0 to 15, full text, stale table, idle mixes, long output hold");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bcs_pkg.sv
hdl/bcs_shift_unit.sv
hdl/bcs_engine.sv
hdl/bad_character_string_search.sv
tb/bcs_search_checker.sv
tb/bad_character_string_search_tb.sv
